// File: rtl/vlcs_pkg.sv
package vlcs_pkg;

    localparam int unsigned RD_W  = 16;
    localparam int unsigned LVL_W = 17;
    localparam int unsigned CFG_W = 16;
    localparam int unsigned IDX_W = 2;
    // normalized quotient: 17 bits, saturates at one
    localparam int unsigned Q_W   = 17;
    // square root of a 33-bit radicand gives 17 bits
    localparam int unsigned S_W   = 17;
    localparam logic [LVL_W-1:0] ONE_Q16 = 17'd65536;

    typedef enum logic [IDX_W-1:0] {
        REG_VU_MAX    = 2'd0,
        REG_SIZE_MIN  = 2'd1,
        REG_SIZE_MAX  = 2'd2,
        REG_OUTER     = 2'd3
    } reg_idx_t;

    localparam logic [CFG_W-1:0] RST_VU_MAX   = 16'd65535;
    localparam logic [CFG_W-1:0] RST_SIZE_MIN = 16'd4096;
    localparam logic [CFG_W-1:0] RST_SIZE_MAX = 16'd8192;
    localparam logic [CFG_W-1:0] RST_OUTER    = 16'd4096;

endpackage

// File: rtl/vlcs_stream_if.sv
interface vlcs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/vlcs_core.sv
// pipelined datapath: restoring divider (one quotient bit per stage), restoring
// square root (one root bit per stage), curve, combine, interpolate, compare
module vlcs_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        item_valid,
    input  logic [15:0] peak_reading,
    input  logic [15:0] rms_reading,
    input  logic [15:0] vu_max,
    input  logic [15:0] size_min,
    input  logic [15:0] size_max,
    input  logic [15:0] outer_scale,
    output logic        result_valid,
    output logic [16:0] level,
    output logic [16:0] peak_level,
    output logic [15:0] scale_factor,
    output logic        extends_beyond
);
    // stage counts
    localparam int unsigned DIV_ST = 17;
    localparam int unsigned SQ_ST  = 17;
    localparam int unsigned TAIL   = 6;
    localparam int unsigned NST    = DIV_ST + SQ_ST + TAIL;

    logic [NST-1:0] vld_reg;

    // ---------------- divider ----------------
    // dividend = reading << 16, 32 bits; quotient saturates at 65536, so
    // a reading >= vu_max is clamped up front and 17 quotient bits suffice
    typedef struct packed {
        logic [32:0] rem;   // partial remainder
        logic [16:0] quo;
        logic        sat;
    } div_t;

    div_t dp_reg [DIV_ST][2];
    div_t dp_next [DIV_ST][2];

    always_comb
    begin
        logic [32:0] trial;
        logic [15:0] rd;
        for (int c = 0; c < 2; c++)
        begin
            for (int s = 0; s < DIV_ST; s++)
            begin
                if (s == 0)
                begin
                    rd = (c == 0) ? peak_reading : rms_reading;
                    dp_next[s][c].sat = (vu_max == 16'd0) ? (rd != 16'd0)
                                                         : (rd >= vu_max);
                    // quotient bit 16 weight: 2^16*vu_max > dividend unless saturated
                    dp_next[s][c].rem = {17'd0, rd};
                    dp_next[s][c].quo = 17'd0;
                end
                else
                begin
                    dp_next[s][c] = dp_reg[s-1][c];
                    trial = {dp_reg[s-1][c].rem[31:0], 1'b0};
                    if (trial >= {17'd0, vu_max} && vu_max != 16'd0)
                    begin
                        dp_next[s][c].rem = trial - {17'd0, vu_max};
                        dp_next[s][c].quo = {dp_reg[s-1][c].quo[15:0], 1'b1};
                    end
                    else
                    begin
                        dp_next[s][c].rem = trial;
                        dp_next[s][c].quo = {dp_reg[s-1][c].quo[15:0], 1'b0};
                    end
                end
            end
        end
    end

    // normalized value after the divider
    logic [16:0] n_val [2];
    always_comb
    begin
        for (int c = 0; c < 2; c++)
            n_val[c] = dp_reg[DIV_ST-1][c].sat ? vlcs_pkg::ONE_Q16
                                                : dp_reg[DIV_ST-1][c].quo;
    end

    // ---------------- square root of n<<16 ----------------
    typedef struct packed {
        logic [33:0] rad;   // remaining radicand
        logic [34:0] rem;
        logic [16:0] root;
        logic [16:0] n;
    } sq_t;

    sq_t sq_reg [SQ_ST][2];
    sq_t sq_next [SQ_ST][2];

    always_comb
    begin
        sq_t  cur;
        logic [34:0] r2;
        logic [34:0] tr;
        for (int c = 0; c < 2; c++)
        begin
            for (int s = 0; s < SQ_ST; s++)
            begin
                if (s == 0)
                begin
                    cur.rad  = {1'b0, n_val[c], 16'd0};
                    cur.rem  = 35'd0;
                    cur.root = 17'd0;
                    cur.n    = n_val[c];
                end
                else
                    cur = sq_reg[s-1][c];
                sq_next[s][c] = cur;
                r2 = {cur.rem[32:0], cur.rad[33:32]};
                tr = {16'd0, cur.root, 2'b01};
                sq_next[s][c].rad = {cur.rad[31:0], 2'b00};
                if (r2 >= tr)
                begin
                    sq_next[s][c].rem  = r2 - tr;
                    sq_next[s][c].root = {cur.root[15:0], 1'b1};
                end
                else
                begin
                    sq_next[s][c].rem  = r2;
                    sq_next[s][c].root = {cur.root[15:0], 1'b0};
                end
            end
        end
    end

    // ---------------- curve ----------------
    // t1: product s*(131072+3n) ; t2: divide by 327680 via reciprocal
    logic [36:0] prod_reg [2];
    logic [36:0] prod_next [2];
    always_comb
    begin
        logic [18:0] k;
        for (int c = 0; c < 2; c++)
        begin
            k = 19'd131072 + 19'(sq_reg[SQ_ST-1][c].n) * 19'd3;
            prod_next[c] = 37'(sq_reg[SQ_ST-1][c].root) * 37'(k) + 37'd163840;
        end
    end

    // /327680 = >>16 then /5; value>>16 < 2^21; /5 by reciprocal and fix
    logic [16:0] p_reg [2];
    logic [16:0] p_next [2];
    always_comb
    begin
        logic [20:0] h;
        logic [41:0] m;
        logic [20:0] q;
        logic [23:0] r;
        for (int c = 0; c < 2; c++)
        begin
            h = prod_reg[c][36:16];
            m = 42'(h) * 42'd838861;     // ceil(2^22/5)
            q = {1'b0, m[41:22]};
            r = 24'(h) - 24'(q) * 24'd5;
            if (r >= 24'd5)
                q = q + 21'd1;
            p_next[c] = q[16:0];
        end
    end

    // combine: peak08 = (4p+2)/5, level = max
    logic [16:0] lvl_reg, pk_reg;
    logic [16:0] lvl_next;
    always_comb
    begin
        logic [18:0] a;
        logic [40:0] m;
        logic [18:0] q;
        logic [21:0] r;
        a = {p_reg[0], 2'b00} + 19'd2;
        m = 41'(a) * 41'd838861;
        q = m[40:22];
        r = 22'(a) - 22'(q) * 22'd5;
        if (r >= 22'd5)
            q = q + 19'd1;
        lvl_next = (p_reg[1] > q[16:0]) ? p_reg[1] : q[16:0];
    end

    // interpolate
    logic [16:0] lvl2_reg, pk2_reg;
    logic [32:0] t_reg;
    logic        dn_reg;
    logic [15:0] smin_reg;
    logic [16:0] lvl3_reg, pk3_reg;
    logic [15:0] scl_reg;
    logic [16:0] lvl4_reg, pk4_reg;
    logic [15:0] scl4_reg;
    logic        ext_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], item_valid};
    end

    always_ff @(posedge clk)
    begin
        logic [15:0] d;
        logic [32:0] tt;
        logic [15:0] sc;
        if (adv)
        begin
            dp_reg   <= dp_next;
            sq_reg   <= sq_next;
            prod_reg <= prod_next;
            p_reg    <= p_next;
            lvl_reg  <= lvl_next;
            pk_reg   <= p_reg[0];
            d = (size_max >= size_min) ? size_max - size_min : size_min - size_max;
            t_reg    <= 33'(lvl_reg) * 33'(d) + 33'd32768;
            dn_reg   <= size_max < size_min;
            smin_reg <= size_min;
            lvl2_reg <= lvl_reg;
            pk2_reg  <= pk_reg;
            tt = t_reg >> 16;
            sc = dn_reg ? smin_reg - tt[15:0] : smin_reg + tt[15:0];
            scl_reg  <= sc;
            lvl3_reg <= lvl2_reg;
            pk3_reg  <= pk2_reg;
            ext_reg  <= (32'(scl_reg) * 32'(outer_scale)) > 32'd16777216;
            scl4_reg <= scl_reg;
            lvl4_reg <= lvl3_reg;
            pk4_reg  <= pk3_reg;
        end
    end

    assign result_valid   = vld_reg[NST-1];
    assign level          = lvl4_reg;
    assign peak_level     = pk4_reg;
    assign scale_factor   = scl4_reg;
    assign extends_beyond = ext_reg;
endmodule

// File: rtl/vu_level_corona_scaler.sv
// pipeline: 40 register stages
// (17 divider, 17 square-root, 6 curve/combine/scale)
// throughput: one reading pair per cycle; the whole pipeline holds on output stall
// reset: pipeline valid bits clear, registers return to vu_max 65535,
// size_min 4096, size_max 8192, outer_layer_scale 4096
module vu_level_corona_scaler (
    input  logic        clk,
    input  logic        rst_n,
    vlcs_stream_if.sink   in_ch,
    vlcs_stream_if.source out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_wdata
);
    logic [15:0] vu_max_reg, smin_reg, smax_reg, outer_reg;
    logic adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vu_max_reg <= vlcs_pkg::RST_VU_MAX;
            smin_reg   <= vlcs_pkg::RST_SIZE_MIN;
            smax_reg   <= vlcs_pkg::RST_SIZE_MAX;
            outer_reg  <= vlcs_pkg::RST_OUTER;
        end
        else if (cfg_we)
        begin
            unique case (vlcs_pkg::reg_idx_t'(cfg_idx))
                vlcs_pkg::REG_VU_MAX:   vu_max_reg <= cfg_wdata;
                vlcs_pkg::REG_SIZE_MIN: smin_reg   <= cfg_wdata;
                vlcs_pkg::REG_SIZE_MAX: smax_reg   <= cfg_wdata;
                vlcs_pkg::REG_OUTER:    outer_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline moves unless a finished result is stalled
    assign adv         = out_ch.ready || !out_ch.valid;
    assign in_ch.ready = adv;

    vlcs_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .item_valid     (in_ch.valid),
        .peak_reading   (in_ch.data.peak_reading),
        .rms_reading    (in_ch.data.rms_reading),
        .vu_max         (vu_max_reg),
        .size_min       (smin_reg),
        .size_max       (smax_reg),
        .outer_scale    (outer_reg),
        .result_valid   (out_ch.valid),
        .level          (out_ch.data.level),
        .peak_level     (out_ch.data.peak_level),
        .scale_factor   (out_ch.data.scale_factor),
        .extends_beyond (out_ch.data.extends_beyond)
    );
endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] peak_reading;
        logic [15:0] rms_reading;
    } reading_t;

    typedef struct packed {
        logic [16:0] level;
        logic [16:0] peak_level;
        logic [15:0] scale_factor;
        logic        extends_beyond;
    } scaled_t;

    class corona_scoreboard;
        logic [15:0] vu_max;
        logic [15:0] size_min;
        logic [15:0] size_max;
        logic [15:0] outer_scale;
        scaled_t     pending[$];
        bit          failed;

        function new();
            vu_max      = vlcs_pkg::RST_VU_MAX;
            size_min    = vlcs_pkg::RST_SIZE_MIN;
            size_max    = vlcs_pkg::RST_SIZE_MAX;
            outer_scale = vlcs_pkg::RST_OUTER;
            failed      = 0;
        endfunction

        function void set_reg(vlcs_pkg::reg_idx_t idx, logic [15:0] value);
            case (idx)
                vlcs_pkg::REG_VU_MAX:   vu_max = value;
                vlcs_pkg::REG_SIZE_MIN: size_min = value;
                vlcs_pkg::REG_SIZE_MAX: size_max = value;
                vlcs_pkg::REG_OUTER:    outer_scale = value;
                default:      ;
            endcase
        endfunction

        function longint unsigned normalize(logic [15:0] reading);
            longint unsigned q;
            if (vu_max == 0)
                return (reading != 0) ? 65536 : 0;
            q = ({48'd0, reading} << 16) / vu_max;
            return (q > 65536) ? 65536 : q;
        endfunction

        function longint unsigned root_of(longint unsigned v);
            longint unsigned r;
            longint unsigned trial;
            r = 0;
            for (int i = 16; i >= 0; i--)
            begin
                trial = r | (64'd1 << i);
                if (trial * trial <= v)
                    r = trial;
            end
            return r;
        endfunction

        function longint unsigned curve(longint unsigned n);
            longint unsigned s;
            s = root_of(n << 16);
            return (s * (131072 + 3 * n) + 163840) / 327680;
        endfunction

        function void note_reading(reading_t rd);
            scaled_t         exp_res;
            longint unsigned pk;
            longint unsigned rm;
            longint unsigned pk08;
            longint unsigned lvl;
            longint unsigned sc;
            pk   = curve(normalize(rd.peak_reading));
            rm   = curve(normalize(rd.rms_reading));
            pk08 = (4 * pk + 2) / 5;
            lvl  = (rm > pk08) ? rm : pk08;
            if (size_max >= size_min)
                sc = size_min + ((lvl * (size_max - size_min) + 32768) >> 16);
            else
                sc = size_min - ((lvl * (size_min - size_max) + 32768) >> 16);
            exp_res.level          = lvl[16:0];
            exp_res.peak_level     = pk[16:0];
            exp_res.scale_factor   = sc[15:0];
            exp_res.extends_beyond = (sc * outer_scale > 64'd16777216);
            pending.push_back(exp_res);
        endfunction

        function void check_result(scaled_t got);
            scaled_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                failed = 1;
                return;
            end
            want = pending.pop_front();
            if (got.level !== want.level)
            begin
                $display("%0t: level expected %0d actual %0d", $time, want.level, got.level);
                failed = 1;
            end
            if (got.peak_level !== want.peak_level)
            begin
                $display("%0t: peak_level expected %0d actual %0d",
                         $time, want.peak_level, got.peak_level);
                failed = 1;
            end
            if (got.scale_factor !== want.scale_factor)
            begin
                $display("%0t: scale_factor expected %0d actual %0d",
                         $time, want.scale_factor, got.scale_factor);
                failed = 1;
            end
            if (got.extends_beyond !== want.extends_beyond)
            begin
                $display("%0t: extends_beyond expected %0d actual %0d",
                         $time, want.extends_beyond, got.extends_beyond);
                failed = 1;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_wdata;
    bit          send_burst;
    bit          recv_burst;
    int          recv_count;

    vlcs_stream_if #(.payload_t(reading_t)) in_ch ();
    vlcs_stream_if #(.payload_t(scaled_t))  out_ch ();

    corona_scoreboard sb = new();

    vu_level_corona_scaler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic write_reg(vlcs_pkg::reg_idx_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic send_reading(logic [15:0] peak, logic [15:0] rms);
        int       gap;
        reading_t rd;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        rd.peak_reading = peak;
        rd.rms_reading  = rms;
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= rd;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_reading(rd);
    endtask

    // block is idle once every result is back and no transfer is in flight
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (45) @(negedge clk);
    endtask

    task automatic random_phase(int count);
        logic [15:0] top;
        int          mode;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 3);
            // keep most readings around the full-scale point so the curve is exercised
            top = (sb.vu_max == 0) ? 16'd3 : sb.vu_max;
            if (mode == 0)
                send_reading(16'($urandom), 16'($urandom));
            else if (mode == 1)
                send_reading(16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)));
            else
                send_reading(16'($urandom_range(0, top)), 16'($urandom_range(0, top)));
        end
    endtask

    task automatic config_phase(logic [15:0] vu, logic [15:0] smin,
                                logic [15:0] smax, logic [15:0] outer);
        write_reg(vlcs_pkg::REG_VU_MAX, vu);
        write_reg(vlcs_pkg::REG_SIZE_MIN, smin);
        write_reg(vlcs_pkg::REG_SIZE_MAX, smax);
        write_reg(vlcs_pkg::REG_OUTER, outer);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = vlcs_pkg::REG_VU_MAX;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        send_burst   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset settings
        send_reading(16'd0, 16'd0);
        send_reading(16'hFFFF, 16'hFFFF);
        send_reading(16'hFFFF, 16'd0);
        send_reading(16'd0, 16'hFFFF);
        send_reading(16'd1, 16'd1);
        send_reading(16'h8000, 16'h7FFF);
        send_reading(16'h5555, 16'hAAAA);
        drain();
        // zero full scale: any nonzero reading is full
        config_phase(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_reading(16'd0, 16'd0);
        send_reading(16'd1, 16'd0);
        send_reading(16'd0, 16'd1);
        send_reading(16'hFFFF, 16'd2);
        drain();
        // falling scale
        config_phase(16'd1, 16'hFFFF, 16'd0, 16'd0);
        send_reading(16'd0, 16'd0);
        send_reading(16'd1, 16'd0);
        send_reading(16'd0, 16'd1);
        send_reading(16'hFFFF, 16'hFFFF);
        drain();
        config_phase(16'd1000, 16'd4096, 16'd4096, 16'd4097);
        send_reading(16'd500, 16'd999);
        send_reading(16'd1000, 16'd1001);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            send_burst = (ph % 3 == 2);
            case (ph)
                0: config_phase(vlcs_pkg::RST_VU_MAX, vlcs_pkg::RST_SIZE_MIN,
                                vlcs_pkg::RST_SIZE_MAX, vlcs_pkg::RST_OUTER);
                1: config_phase(16'd1, 16'd0, 16'hFFFF, 16'd1);
                2: config_phase(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
                3: config_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
                default: config_phase(16'($urandom_range(1, 65535) >> $urandom_range(0, 15)),
                                      16'($urandom), 16'($urandom),
                                      16'($urandom_range(0, 12288)));
            endcase
            random_phase(190);
            drain();
        end

        if (!sb.failed)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        recv_burst   = 0;
        recv_count   = 0;
        forever
        begin
            int stall;
            stall = recv_burst ? 0 : $urandom_range(0, 10);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && rst_n));
            sb.check_result(out_ch.data);
            recv_count++;
            if (recv_count % 300 == 0)
                recv_burst = !recv_burst;
        end
    end

    initial
    begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
